>>> src/stlc_pkg.sv
// Sheet tag LRU cache: shared constants, types and helpers.
// Used by stlc_scan and sheet_tag_lru_cache.
package stlc_pkg;

	localparam int CAPACITY    = 16;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int REC_W       = IDX_W;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int SHEET_W     = 8;
	localparam int SLOT_W      = 4;
	localparam int TOTAL_W     = 32;
	localparam logic [SHEET_W-1:0] SHEET_LIMIT = 8'd223;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [REC_W-1:0]   rec_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [SHEET_W-1:0] sheet_t;
	typedef logic [TOTAL_W-1:0] total_t;

	typedef enum logic [2:0] {
		ST_HIT     = 3'd0,
		ST_LOADED  = 3'd1,
		ST_UNAVAIL = 3'd2,
		ST_INVALID = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	// One word of the entry memory
	typedef struct packed {
		sheet_t sheet;
		rec_t   rec;
	} entry_t;

	// Outcome of one search pass over the entry memory
	typedef struct packed {
		logic   hit;
		idx_t   hit_idx;
		rec_t   hit_rec;
		logic   free;
		idx_t   free_idx;
		idx_t   old_idx;
		rec_t   old_rec;
		sheet_t old_sheet;
	} scan_res_t;

	// Entry number as reported on the slot field, masked to four bits
	function automatic logic [SLOT_W-1:0] to_slot(input idx_t idx);
		logic [IDX_W+SLOT_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide[SLOT_W-1:0];
	endfunction

endpackage

>>> src/stlc_in_if.sv
// Request channel of the sheet tag LRU cache: valid/ready plus lookup fields.
// Depends on nothing.
interface stlc_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] sheet_num;
	logic       sheet_available;

	modport source (output valid, mode, sheet_num, sheet_available, input ready);
	modport sink   (input valid, mode, sheet_num, sheet_available, output ready);
endinterface

>>> src/stlc_out_if.sv
// Response channel of the sheet tag LRU cache: valid/ready plus result fields.
// Depends on nothing.
interface stlc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  slot;
	logic        evicted;
	logic [7:0]  evicted_sheet;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] load_total;

	modport source (output valid, status, slot, evicted, evicted_sheet, hit_total,
		miss_total, load_total, input ready);
	modport sink   (input valid, status, slot, evicted, evicted_sheet, hit_total,
		miss_total, load_total, output ready);
endinterface

>>> src/stlc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module stlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/stlc_scan.sv
// Search tracker: watches the entry stream of a read pass and keeps the first
// match, the first free entry and the oldest entry. Depends on stlc_pkg.
module stlc_scan
	import stlc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      strobe,
	input  idx_t      idx,
	input  logic      ent_valid,
	input  entry_t    ent,
	input  sheet_t    sheet,
	output scan_res_t res
);

	scan_res_t res_q;

	// Restart on a new transaction, fold in each entry as it streams past
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (start) begin
			res_q <= '0;
		end else if (strobe) begin
			if (!res_q.hit && ent_valid && ent.sheet == sheet) begin
				res_q.hit     <= 1'b1;
				res_q.hit_idx <= idx;
				res_q.hit_rec <= ent.rec;
			end
			if (!res_q.free && !ent_valid) begin
				res_q.free     <= 1'b1;
				res_q.free_idx <= idx;
			end
			// Later entries win ties, as the oldest is the last highest rank
			if (ent.rec >= res_q.old_rec) begin
				res_q.old_idx   <= idx;
				res_q.old_rec   <= ent.rec;
				res_q.old_sheet <= ent.sheet;
			end
		end
	end

	assign res = res_q;

	// A recorded hit never moves once found
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_q.hit && !start) |=> $stable(res_q.hit_idx))
		else $error("hit entry changed during a search pass");

endmodule

>>> src/sheet_tag_lru_cache.sv
// Sheet tag LRU cache, top level: sequencer, valid bits, counters, result register.
// Depends on stlc_pkg, stlc_in_if, stlc_out_if, stlc_ram and stlc_scan.
//
// A fully associative cache of CAPACITY sheet numbers with least-recently-used
// replacement. Each request transaction is a lookup or a clear and yields exactly
// one response. Sheet and recency rank of every entry live in one memory with a
// single read port, so a lookup reads every entry once to search it and, on a hit
// or a load, once more to age the ranks and write them back. A miss that cannot be
// loaded is only searched; a clear or an invalid sheet number reads no entry. A full
// output register holds the response back; the next request is taken the cycle after
// the response is loaded. Valid bits are flip-flops, so a clear is immediate and no
// clearing pass follows reset. A new request is taken while the previous response
// still waits in the output register.
module sheet_tag_lru_cache
	import stlc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	stlc_in_if.sink           req,
	stlc_out_if.source        rsp
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_UPD    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t              state_q;
	cnt_t                cnt_q;
	logic                rd_vld_s1;
	idx_t                rd_idx_s1;
	logic [CAPACITY-1:0] valid_q;
	total_t              hit_q, miss_q, load_q;
	logic                rsp_vld_q;

	sheet_t              sheet_q;
	logic                avail_q;
	idx_t                target_q;
	rec_t                limit_q;
	logic                all_q;
	status_t             res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                res_evicted_q;
	sheet_t              res_ev_sheet_q;

	logic [2:0]          out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_evicted_q;
	sheet_t              out_ev_sheet_q;
	total_t              out_hit_q, out_miss_q, out_load_q;

	logic                acc;
	logic                rd_en;
	logic                drained;
	logic                out_load;
	logic                wr_en;
	entry_t              rd_ent;
	entry_t              wr_ent;
	scan_res_t           scan;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign rd_en     = (state_q == S_SCAN || state_q == S_UPD) && cnt_q != cnt_t'(CAPACITY);
	assign drained   = (cnt_q == cnt_t'(CAPACITY)) && !rd_vld_s1;
	assign out_load  = (state_q == S_DONE) && (!rsp_vld_q || rsp.ready);

	// Entry memory: reads run one address ahead of the write-back, so a
	// read and a write never meet on the same entry
	stlc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rd_idx_s1),
		.wdata (wr_ent),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (rd_ent)
	);

	stlc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (acc),
		.strobe    (rd_vld_s1 && state_q == S_SCAN),
		.idx       (rd_idx_s1),
		.ent_valid (valid_q[rd_idx_s1]),
		.ent       (rd_ent),
		.sheet     (sheet_q),
		.res       (scan)
	);

	// Write back: target becomes the newest, younger valid entries age by one
	always_comb begin
		wr_en  = (state_q == S_UPD) && rd_vld_s1;
		wr_ent = rd_ent;
		if (rd_idx_s1 == target_q) begin
			wr_ent.sheet = sheet_q;
			wr_ent.rec   = '0;
		end else if (valid_q[rd_idx_s1] && (all_q || rd_ent.rec < limit_q)) begin
			wr_ent.rec = rec_t'(rd_ent.rec + 1'b1);
		end
	end

	// Sequencer, valid bits and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			valid_q   <= '0;
			hit_q     <= '0;
			miss_q    <= '0;
			load_q    <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				cnt_q <= cnt_t'(cnt_q + 1'b1);
			end
			if (out_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						cnt_q <= '0;
						if (req.mode) begin
							valid_q <= '0;
							state_q <= S_DONE;
						end else if (req.sheet_num >= SHEET_LIMIT) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (drained) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cnt_q <= '0;
					if (scan.hit) begin
						hit_q   <= hit_q + 1'b1;
						state_q <= S_UPD;
					end else if (!avail_q) begin
						miss_q  <= miss_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						miss_q  <= miss_q + 1'b1;
						load_q  <= load_q + 1'b1;
						state_q <= S_UPD;
						if (scan.free) begin
							valid_q[scan.free_idx] <= 1'b1;
						end
					end
				end
				S_UPD: begin
					if (drained) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Transaction payload and result fields
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
		if (acc) begin
			sheet_q        <= req.sheet_num;
			avail_q        <= req.sheet_available;
			res_slot_q     <= '0;
			res_evicted_q  <= 1'b0;
			res_ev_sheet_q <= '0;
			if (req.mode) begin
				res_status_q <= ST_CLEARED;
			end else if (req.sheet_num >= SHEET_LIMIT) begin
				res_status_q <= ST_INVALID;
			end else begin
				res_status_q <= ST_UNAVAIL;
			end
		end
		if (state_q == S_DECIDE) begin
			if (scan.hit) begin
				res_status_q <= ST_HIT;
				res_slot_q   <= to_slot(scan.hit_idx);
				target_q     <= scan.hit_idx;
				limit_q      <= scan.hit_rec;
				all_q        <= 1'b0;
			end else if (avail_q) begin
				res_status_q <= ST_LOADED;
				if (scan.free) begin
					res_slot_q <= to_slot(scan.free_idx);
					target_q   <= scan.free_idx;
					limit_q    <= '0;
					all_q      <= 1'b1;
				end else begin
					res_slot_q     <= to_slot(scan.old_idx);
					res_evicted_q  <= 1'b1;
					res_ev_sheet_q <= scan.old_sheet;
					target_q       <= scan.old_idx;
					limit_q        <= scan.old_rec;
					all_q          <= 1'b0;
				end
			end
		end
		if (out_load) begin
			out_status_q   <= res_status_q;
			out_slot_q     <= res_slot_q;
			out_evicted_q  <= res_evicted_q;
			out_ev_sheet_q <= res_ev_sheet_q;
			out_hit_q      <= hit_q;
			out_miss_q     <= miss_q;
			out_load_q     <= load_q;
		end
	end

	// Drive the response channel from the output register
	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = out_status_q;
	assign rsp.slot          = out_slot_q;
	assign rsp.evicted       = out_evicted_q;
	assign rsp.evicted_sheet = out_ev_sheet_q;
	assign rsp.hit_total     = out_hit_q;
	assign rsp.miss_total    = out_miss_q;
	assign rsp.load_total    = out_load_q;

	// The memory is written only during the write-back pass
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == S_UPD)
		else $error("entry memory written outside the write-back pass");

	// A clear leaves every entry invalid
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.mode) |=> valid_q == '0)
		else $error("clear did not empty the table");

	// A found entry is a valid one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && scan.hit) |-> valid_q[scan.hit_idx])
		else $error("hit reported on an invalid entry");

	// Eviction happens only with a full table
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && !scan.hit && avail_q && !scan.free) |-> (&valid_q))
		else $error("eviction chosen while a free entry exists");

endmodule
